### sv/acf_pkg.sv
// acf_pkg: shared types, constants and the microcode table of the altitude filter
// used by acf_div, acf_dp, acf_seq and altitude_complementary_filter
// no dependencies
package acf_pkg;

    // datapath widths
    localparam int ACC_W     = 64;   // signed accumulator
    localparam int TMP_W     = 40;   // magnitude of a rounded value
    localparam int MA_W      = 32;   // multiplier operand a (magnitude)
    localparam int MB_W      = 20;   // multiplier operand b (unsigned gain)
    localparam int PROD_W    = MA_W + MB_W;
    localparam int PC_W      = 5;

    // divider: 52-bit dividend, four quotient bits per pass
    localparam int QUO_W        = 52;
    localparam int DIV_BITS     = 4;
    localparam int DIV_ITER     = QUO_W / DIV_BITS;
    localparam int DIV_CNT_W    = 4;

    // fixed-point constants
    localparam logic [MB_W-1:0] GRAVITY_Q16 = 20'd642908;  // 9.81 in Q16.16
    localparam logic [MB_W-1:0] ONE_Q16     = 20'd65536;

    // configuration reset values
    localparam logic [15:0] BLEND_GAIN_RST = 16'd52429;
    localparam logic [17:0] VEL_WEIGHT_RST = 18'd65536;
    localparam logic [15:0] DEADBAND_RST   = 16'd2621;
    localparam logic [15:0] VEL_DECAY_RST  = 16'd65208;

    // request kinds carried in tuser
    localparam logic REQ_ACCEL = 1'b0;
    localparam logic REQ_ALT   = 1'b1;

    // register map indexes
    typedef enum logic [1:0] {
        REG_BLEND_GAIN = 2'd0,
        REG_VEL_WEIGHT = 2'd1,
        REG_DEADBAND   = 2'd2,
        REG_VEL_DECAY  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] blend_gain;
        logic [17:0] vel_weight;
        logic [15:0] deadband;
        logic [15:0] vel_decay;
    } cfg_t;

    // multiplier operand a sources
    typedef enum logic [2:0] {
        MA_ADB    = 3'd0,   // acceleration after deadband
        MA_TMP_LO = 3'd1,   // rounded value, low word
        MA_TMP_HI = 3'd2,   // rounded value, high byte
        MA_VEL    = 3'd3,
        MA_OLD    = 3'd4,   // stored height estimate
        MA_ALT    = 3'd5
    } mul_a_t;

    // multiplier operand b sources
    typedef enum logic [2:0] {
        MB_DT    = 3'd0,
        MB_GRAV  = 3'd1,
        MB_DECAY = 3'd2,
        MB_GAIN  = 3'd3,
        MB_GAINC = 3'd4,    // one minus blend gain
        MB_ONE   = 3'd5,
        MB_VW    = 3'd6
    } mul_b_t;

    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD  = 2'd2
    } acc_op_t;

    typedef enum logic [1:0] {
        RND_NONE = 2'd0,
        RND_0    = 2'd1,
        RND_16   = 2'd2,
        RND_32   = 2'd3
    } rnd_t;

    typedef enum logic [2:0] {
        WR_NONE = 3'd0,
        WR_VADD = 3'd1,     // velocity += rounded value, saturated
        WR_VSET = 3'd2,     // velocity = rounded value
        WR_BSET = 3'd3,     // blend = rounded value
        WR_HADD = 3'd4,     // new height = blend + rounded value, saturated
        WR_DIFF = 3'd5      // height change, divider start, commit height
    } wr_t;

    typedef enum logic [2:0] {
        SQ_NEXT    = 3'd0,
        SQ_JMP     = 3'd1,
        SQ_JHZ     = 3'd2,  // jump when the height estimate is zero
        SQ_WAITDIV = 3'd3,
        SQ_OUT     = 3'd4,  // hand over the result, then stop
        SQ_END     = 3'd5
    } sq_op_t;

    typedef struct packed {
        mul_a_t          mul_a;
        mul_b_t          mul_b;
        acc_op_t         acc_op;
        logic            acc_sh32;
        rnd_t            rnd;
        wr_t             wr;
        sq_op_t          sq;
        logic [PC_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic hzero;
        logic div_busy;
    } dp_status_t;

    typedef enum logic [1:0] {
        SEQ_IDLE = 2'b01,
        SEQ_RUN  = 2'b10
    } seq_state_t;

    localparam ucode_t UCODE_NOP = '0;

    // program entry points and jump targets
    localparam logic [PC_W-1:0] PC_ACCEL     = 5'd0;
    localparam logic [PC_W-1:0] PC_ALT       = 5'd12;
    localparam logic [PC_W-1:0] PC_ALT_ONE   = 5'd16;
    localparam logic [PC_W-1:0] PC_BLEND_RND = 5'd18;

    // microcode table
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        w = UCODE_NOP;
        case (pc)
            // acceleration item: |adb| * dt
            5'd0: begin w.mul_a = MA_ADB; w.mul_b = MB_DT; end
            5'd1: begin w.acc_op = ACC_LOAD; end
            5'd2: begin w.rnd = RND_0; end
            // times gravity in two partial products
            5'd3: begin w.mul_a = MA_TMP_LO; w.mul_b = MB_GRAV; end
            5'd4: begin
                w.mul_a = MA_TMP_HI; w.mul_b = MB_GRAV; w.acc_op = ACC_LOAD;
            end
            5'd5: begin w.acc_op = ACC_ADD; w.acc_sh32 = 1'b1; end
            5'd6: begin w.rnd = RND_32; end
            5'd7: begin w.wr = WR_VADD; end
            // velocity decay
            5'd8: begin w.mul_a = MA_VEL; w.mul_b = MB_DECAY; end
            5'd9: begin w.acc_op = ACC_LOAD; end
            5'd10: begin w.rnd = RND_16; end
            5'd11: begin w.wr = WR_VSET; w.sq = SQ_END; end
            // altitude item: blend into the estimate
            5'd12: begin w.sq = SQ_JHZ; w.target = PC_ALT_ONE; end
            5'd13: begin w.mul_a = MA_OLD; w.mul_b = MB_GAIN; end
            5'd14: begin
                w.mul_a = MA_ALT; w.mul_b = MB_GAINC; w.acc_op = ACC_LOAD;
            end
            5'd15: begin w.acc_op = ACC_ADD; w.sq = SQ_JMP; w.target = PC_BLEND_RND; end
            // zero estimate: take the altitude as is
            5'd16: begin w.mul_a = MA_ALT; w.mul_b = MB_ONE; end
            5'd17: begin w.acc_op = ACC_LOAD; end
            5'd18: begin w.rnd = RND_16; end
            5'd19: begin w.wr = WR_BSET; end
            // velocity term
            5'd20: begin w.mul_a = MA_VEL; w.mul_b = MB_DT; end
            5'd21: begin w.acc_op = ACC_LOAD; end
            5'd22: begin w.rnd = RND_16; end
            5'd23: begin w.mul_a = MA_TMP_LO; w.mul_b = MB_VW; end
            5'd24: begin w.acc_op = ACC_LOAD; end
            5'd25: begin w.rnd = RND_16; end
            5'd26: begin w.wr = WR_HADD; end
            // climb rate
            5'd27: begin w.wr = WR_DIFF; end
            5'd28: begin w.sq = SQ_WAITDIV; end
            5'd29: begin w.sq = SQ_OUT; end
            default: begin w.sq = SQ_END; end
        endcase
        return w;
    endfunction

endpackage

### sv/acf_div.sv
// acf_div: unsigned restoring divider, four quotient bits per pass
// depends on acf_pkg
module acf_div
    import acf_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [QUO_W-1:0] dividend,
    input  logic [15:0]      divisor,
    output logic             busy,
    output logic [QUO_W-1:0] quotient
);

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [QUO_W-1:0]     nq_reg, nq_next;     // dividend bits out, quotient bits in
    logic [15:0]          rem_reg, rem_next;
    logic [15:0]          den_reg, den_next;

    // one pass: four dependent shift-subtract steps on 17-bit values
    always_comb begin
        logic [16:0]      trial;
        logic [15:0]      r;
        logic [QUO_W-1:0] nq;
        r  = rem_reg;
        nq = nq_reg;
        for (int k = 0; k < DIV_BITS; k++) begin
            trial = {r, nq[QUO_W-1]};
            nq    = {nq[QUO_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg}) begin
                r     = 16'(trial - {1'b0, den_reg});
                nq[0] = 1'b1;
            end else begin
                r = trial[15:0];
            end
        end

        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        nq_next   = nq_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_ITER - 1);
            nq_next   = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end else if (busy_reg) begin
            nq_next  = nq;
            rem_next = r;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        nq_reg  <= nq_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy     = busy_reg;
    assign quotient = nq_reg;

endmodule

### sv/acf_dp.sv
// acf_dp: filter datapath: shared multiplier, accumulator, rounding and state
// depends on acf_pkg and acf_div
module acf_dp
    import acf_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_load,
    input  logic signed [21:0] in_accel_z,
    input  logic signed [31:0] in_altitude,
    input  logic [15:0]        in_step_time,
    input  cfg_t               cfg,
    input  ucode_t             ctl,
    output dp_status_t         status,
    output logic [31:0]        res_height,
    output logic [31:0]        res_climb
);

    localparam logic signed [41:0] S42_MAX = 42'sd2147483647;
    localparam logic signed [41:0] S42_MIN = -42'sd2147483648;

    function automatic logic [31:0] abs32(input logic signed [31:0] x);
        return x[31] ? 32'(-x) : 32'(x);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [41:0] x);
        if (x > S42_MAX) begin
            return 32'sh7FFF_FFFF;
        end else if (x < S42_MIN) begin
            return 32'sh8000_0000;
        end
        return x[31:0];
    endfunction

    // latched input item
    logic signed [21:0] az_reg;
    logic signed [31:0] alt_reg;
    logic [15:0]        dt_reg;

    // filter state and intermediates
    logic signed [31:0]      vel_reg, vel_next;
    logic signed [31:0]      height_reg, height_next;
    logic signed [32:0]      blend_reg, blend_next;
    logic signed [31:0]      nh_reg, nh_next;
    logic [PROD_W-1:0]       prod_reg;
    logic                    prod_sign_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [TMP_W-1:0]        tmp_mag_reg, tmp_mag_next;
    logic                    tmp_sign_reg, tmp_sign_next;
    logic                    diff_neg_reg, diff_neg_next;
    logic                    diff_nz_reg, diff_nz_next;

    logic signed [22:0] az_x, db_x, adb;
    logic               adb_neg;
    logic [21:0]        adb_mag;
    logic [MA_W-1:0]    ma;
    logic [MB_W-1:0]    mb;
    logic               sa;
    logic [ACC_W-1:0]   acc_mag, addend_mag;
    logic signed [ACC_W-1:0] addend;
    logic signed [40:0] tmp_val, tmp_pos;
    logic signed [32:0] diff;
    logic [32:0]        diff_mag;
    logic               div_start, div_busy;
    logic [QUO_W-1:0]   dividend, quot;
    logic               q_big;

    // deadband: shrink toward zero by the threshold
    always_comb begin
        az_x = $signed({az_reg[21], az_reg});
        db_x = $signed({7'b0, cfg.deadband});
        if (az_x > db_x) begin
            adb = az_x - db_x;
        end else if (az_x < -db_x) begin
            adb = az_x + db_x;
        end else begin
            adb = '0;
        end
        adb_neg = adb[22];
        adb_mag = adb_neg ? 22'(-adb) : adb[21:0];
    end

    // multiplier operand selection, sign travels beside the magnitude
    always_comb begin
        case (ctl.mul_a)
            MA_ADB:    begin ma = {10'b0, adb_mag};               sa = adb_neg;       end
            MA_TMP_LO: begin ma = tmp_mag_reg[31:0];              sa = tmp_sign_reg;  end
            MA_TMP_HI: begin ma = {24'b0, tmp_mag_reg[39:32]};    sa = tmp_sign_reg;  end
            MA_VEL:    begin ma = abs32(vel_reg);                 sa = vel_reg[31];   end
            MA_OLD:    begin ma = abs32(height_reg);              sa = height_reg[31]; end
            MA_ALT:    begin ma = abs32(alt_reg);                 sa = alt_reg[31];   end
            default:   begin ma = '0;                             sa = 1'b0;          end
        endcase
        case (ctl.mul_b)
            MB_DT:    mb = {4'b0, dt_reg};
            MB_GRAV:  mb = GRAVITY_Q16;
            MB_DECAY: mb = {4'b0, cfg.vel_decay};
            MB_GAIN:  mb = {4'b0, cfg.blend_gain};
            MB_GAINC: mb = ONE_Q16 - {4'b0, cfg.blend_gain};
            MB_ONE:   mb = ONE_Q16;
            MB_VW:    mb = {2'b0, cfg.vel_weight};
            default:  mb = '0;
        endcase
    end

    // accumulator
    always_comb begin
        addend_mag = ctl.acc_sh32 ? {prod_reg[31:0], 32'b0}
                                  : {{(ACC_W-PROD_W){1'b0}}, prod_reg};
        addend     = prod_sign_reg ? -$signed(addend_mag) : $signed(addend_mag);
        case (ctl.acc_op)
            ACC_LOAD: acc_next = addend;
            ACC_ADD:  acc_next = acc_reg + addend;
            default:  acc_next = acc_reg;
        endcase
    end

    // rounding half away from zero on the magnitude
    always_comb begin
        acc_mag       = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        tmp_sign_next = tmp_sign_reg;
        tmp_mag_next  = tmp_mag_reg;
        case (ctl.rnd)
            RND_0: begin
                tmp_sign_next = acc_reg[ACC_W-1];
                tmp_mag_next  = TMP_W'(acc_mag);
            end
            RND_16: begin
                tmp_sign_next = acc_reg[ACC_W-1];
                tmp_mag_next  = TMP_W'((acc_mag + 64'h8000) >> 16);
            end
            RND_32: begin
                tmp_sign_next = acc_reg[ACC_W-1];
                tmp_mag_next  = TMP_W'((acc_mag + 64'h8000_0000) >> 32);
            end
            default: ;
        endcase
    end

    // state write-back
    always_comb begin
        tmp_pos = $signed({1'b0, tmp_mag_reg});
        tmp_val = tmp_sign_reg ? -tmp_pos : tmp_pos;
        diff     = $signed({nh_reg[31], nh_reg}) - $signed({height_reg[31], height_reg});
        diff_mag = diff[32] ? 33'(-diff) : 33'(diff);

        vel_next      = vel_reg;
        height_next   = height_reg;
        blend_next    = blend_reg;
        nh_next       = nh_reg;
        diff_neg_next = diff_neg_reg;
        diff_nz_next  = diff_nz_reg;
        div_start     = 1'b0;
        case (ctl.wr)
            WR_VADD: vel_next = sat32($signed({{10{vel_reg[31]}}, vel_reg})
                                      + $signed({tmp_val[40], tmp_val}));
            WR_VSET: vel_next = sat32($signed({tmp_val[40], tmp_val}));
            WR_BSET: blend_next = tmp_val[32:0];
            WR_HADD: nh_next = sat32($signed({{9{blend_reg[32]}}, blend_reg})
                                     + $signed({tmp_val[40], tmp_val}));
            WR_DIFF: begin
                diff_neg_next = diff[32];
                diff_nz_next  = |diff;
                height_next   = nh_reg;
                div_start     = 1'b1;
            end
            default: ;
        endcase
    end

    // dividend: (|diff| << 16) + dt/2
    assign dividend = QUO_W'({diff_mag, 16'b0}) + QUO_W'(dt_reg[15:1]);

    acf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (dt_reg),
        .busy     (div_busy),
        .quotient (quot)
    );

    // climb rate with saturation and the zero step time case
    always_comb begin
        q_big = |quot[QUO_W-1:31];
        if (!diff_nz_reg) begin
            res_climb = '0;
        end else if (dt_reg == '0) begin
            res_climb = diff_neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else if (diff_neg_reg) begin
            res_climb = q_big ? 32'h8000_0000 : 32'(-quot[31:0]);
        end else begin
            res_climb = q_big ? 32'h7FFF_FFFF : quot[31:0];
        end
    end

    assign res_height      = nh_reg;
    assign status.hzero    = (height_reg == '0);
    assign status.div_busy = div_busy;

    // filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vel_reg    <= '0;
            height_reg <= '0;
        end else begin
            vel_reg    <= vel_next;
            height_reg <= height_next;
        end
    end

    // payload and working registers
    always_ff @(posedge aclk) begin
        if (in_load) begin
            az_reg  <= in_accel_z;
            alt_reg <= in_altitude;
            dt_reg  <= in_step_time;
        end
        prod_reg      <= PROD_W'(ma) * PROD_W'(mb);
        prod_sign_reg <= sa;
        acc_reg       <= acc_next;
        tmp_mag_reg   <= tmp_mag_next;
        tmp_sign_reg  <= tmp_sign_next;
        blend_reg     <= blend_next;
        nh_reg        <= nh_next;
        diff_neg_reg  <= diff_neg_next;
        diff_nz_reg   <= diff_nz_next;
    end

endmodule

### sv/acf_seq.sv
// acf_seq: step counter, microcode table lookup and conditional jumps
// depends on acf_pkg
module acf_seq
    import acf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       start,
    input  logic       start_alt,
    input  dp_status_t status,
    input  logic       out_space,
    output ucode_t     ctl,
    output logic       idle,
    output logic       emit
);

    seq_state_t      state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    ucode_t          word;

    assign word = ucode_rom(pc_reg);
    assign ctl  = (state_reg == SEQ_RUN) ? word : UCODE_NOP;
    assign idle = (state_reg == SEQ_IDLE);

    // next step
    always_comb begin
        state_next = state_reg;
        pc_next    = pc_reg;
        emit       = 1'b0;
        case (state_reg)
            SEQ_IDLE: begin
                if (start) begin
                    state_next = SEQ_RUN;
                    pc_next    = start_alt ? PC_ALT : PC_ACCEL;
                end
            end
            SEQ_RUN: begin
                case (word.sq)
                    SQ_NEXT: pc_next = PC_W'(pc_reg + 1'b1);
                    SQ_JMP:  pc_next = word.target;
                    SQ_JHZ:  pc_next = status.hzero ? word.target : PC_W'(pc_reg + 1'b1);
                    SQ_WAITDIV: begin
                        if (!status.div_busy) begin
                            pc_next = PC_W'(pc_reg + 1'b1);
                        end
                    end
                    SQ_OUT: begin
                        if (out_space) begin
                            emit       = 1'b1;
                            state_next = SEQ_IDLE;
                        end
                    end
                    default: state_next = SEQ_IDLE;
                endcase
            end
            default: state_next = SEQ_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SEQ_IDLE;
            pc_reg    <= '0;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

endmodule

### sv/altitude_complementary_filter.sv
// altitude_complementary_filter: top level, stream ports, register file, output register
// depends on acf_pkg, acf_seq, acf_dp (which holds acf_div)
//
//  channel  | direction | transfer carries
//  ---------+-----------+---------------------------------------------------------
//  s_       | in        | tuser: req_type; tdata: accel_z, altitude, step_time
//  m_       | out       | tdata: height, climb_rate (altitude items only)
//  apb      | in/out    | four filter registers at byte addresses 0, 4, 8, 12
//
// an acceleration item holds s_tready low after its transfer for its 12 microcode steps;
// an altitude item for its 16 steps, or 15 when the estimate is zero, on the shared
// 32x20 multiplier, the divider wait step holding while the radix-16 divider makes
// its 13 passes for the climb rate
// one item at a time; s_tready is high whenever the sequencer is idle
// a result waits in the output register while the next item is taken; the final
// step holds only if the previous result has still not been taken
// reset is synchronous, active low; estimate and velocity clear to zero
module altitude_complementary_filter
    import acf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // accel_z[21:0], altitude[53:22], step_time[69:54]
    input  logic        s_tuser,   // req_type
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // height[31:0], climb_rate[63:32]
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t        cfg_reg, cfg_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [63:0] m_tdata_reg;
    logic        in_xfer, out_space, seq_idle, seq_emit;
    ucode_t      ctl;
    dp_status_t  status;
    logic [31:0] res_height, res_climb;
    reg_idx_t    reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[3:2]);

    // register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                REG_BLEND_GAIN: cfg_next.blend_gain = pwdata[15:0];
                REG_VEL_WEIGHT: cfg_next.vel_weight = pwdata[17:0];
                REG_DEADBAND:   cfg_next.deadband   = pwdata[15:0];
                REG_VEL_DECAY:  cfg_next.vel_decay  = pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        case (reg_idx)
            REG_BLEND_GAIN: prdata = {16'b0, cfg_reg.blend_gain};
            REG_VEL_WEIGHT: prdata = {14'b0, cfg_reg.vel_weight};
            REG_DEADBAND:   prdata = {16'b0, cfg_reg.deadband};
            REG_VEL_DECAY:  prdata = {16'b0, cfg_reg.vel_decay};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.blend_gain <= BLEND_GAIN_RST;
            cfg_reg.vel_weight <= VEL_WEIGHT_RST;
            cfg_reg.deadband   <= DEADBAND_RST;
            cfg_reg.vel_decay  <= VEL_DECAY_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // input handshake
    assign s_tready  = seq_idle;
    assign in_xfer   = s_tvalid && s_tready;
    assign out_space = !m_tvalid_reg || m_tready;

    acf_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (in_xfer),
        .start_alt (s_tuser == REQ_ALT),
        .status    (status),
        .out_space (out_space),
        .ctl       (ctl),
        .idle      (seq_idle),
        .emit      (seq_emit)
    );

    acf_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_load      (in_xfer),
        .in_accel_z   ($signed(s_tdata[21:0])),
        .in_altitude  ($signed(s_tdata[53:22])),
        .in_step_time (s_tdata[69:54]),
        .cfg          (cfg_reg),
        .ctl          (ctl),
        .status       (status),
        .res_height   (res_height),
        .res_climb    (res_climb)
    );

    // output register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (seq_emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (seq_emit) begin
            m_tdata_reg <= {res_climb, res_height};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // checks on sequencing
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> !s_tready)
        else $error("sequencer still idle after taking an item");

    a_emit_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_emit |-> out_space)
        else $error("result written over one not yet taken");

    a_div_free_at_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.wr == WR_DIFF) |-> !status.div_busy)
        else $error("divider started while busy");

    a_idle_after_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_emit |=> s_tready)
        else $error("sequencer not idle after handing over a result");

endmodule
